### hw/rtl/bounce_easing_curve_macros.svh
// Assertion macros for the bounce easing curve block.
// Expect clk and rst_n in the scope where they are used; empty under SYNTHESIS.
`ifndef BOUNCE_EASING_CURVE_MACROS_SVH
`define BOUNCE_EASING_CURVE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define BEC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication
`define BEC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BEC_ASSERT_IMPL(lbl, ante, cons, msg)
`define BEC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/bec_pkg.sv
// Shared types and codes for the bounce easing curve pipeline.
// No dependencies.
`timescale 1ns / 1ps

package bec_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_VARIANT  = 2'd0;
    localparam logic [1:0] REG_DURATION = 2'd1;
    localparam logic [1:0] REG_START    = 2'd2;
    localparam logic [1:0] REG_CHANGE   = 2'd3;

    // Variant register codes
    localparam logic [1:0] VAR_IN    = 2'd0;
    localparam logic [1:0] VAR_OUT   = 2'd1;
    localparam logic [1:0] VAR_INOUT = 2'd2;

    localparam int DUR_BITS = 16;
    localparam int VAL_BITS = 32;

    // How the curve value is folded after the ease-out evaluation
    typedef logic [1:0] mode_t;
    localparam mode_t MODE_OUT = 2'd0;
    localparam mode_t MODE_IN  = 2'd1;
    localparam mode_t MODE_LO  = 2'd2;
    localparam mode_t MODE_HI  = 2'd3;

endpackage

### hw/rtl/bec_prep.sv
// Entry stage: clamp the elapsed time and form the ease-out argument.
// Depends on bec_pkg.
`timescale 1ns / 1ps

module bec_prep import bec_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           variant,
    input  logic [TIME_BITS-1:0] dur,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic [TIME_BITS-1:0] elapsed,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic [TIME_BITS-1:0] arg,
    output mode_t                mode
);

    logic                 v_reg;
    logic [TIME_BITS-1:0] arg_reg, arg_next;
    mode_t                mode_reg, mode_next;
    logic [TIME_BITS-1:0] t;
    logic [TIME_BITS:0]   t2;
    logic [TIME_BITS:0]   d1;
    logic [TIME_BITS:0]   diff;

    assign up_ready = !v_reg || dn_ready;

    // Clamp and pick the argument per variant
    always_comb
    begin
        t  = (elapsed > dur) ? dur : elapsed;
        t2 = {t, 1'b0};
        d1 = {1'b0, dur};
        diff = '0;
        unique case (variant)
            VAR_IN:
            begin
                arg_next  = dur - t;
                mode_next = MODE_IN;
            end
            VAR_INOUT:
            begin
                if (t2 < d1)
                begin
                    diff      = d1 - t2;
                    mode_next = MODE_LO;
                end
                else
                begin
                    diff      = t2 - d1;
                    mode_next = MODE_HI;
                end
                arg_next = diff[TIME_BITS-1:0];
            end
            default:
            begin
                arg_next  = t;
                mode_next = MODE_OUT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_ready)
            v_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            arg_reg  <= arg_next;
            mode_reg <= mode_next;
        end
    end

    assign dn_valid = v_reg;
    assign arg      = arg_reg;
    assign mode     = mode_reg;

endmodule

### hw/rtl/bec_div.sv
// Pipelined restoring divider: ratio = floor(arg * 2^FRAC_BITS / dur), one bit a stage.
// Depends on bec_pkg.
`timescale 1ns / 1ps

module bec_div import bec_pkg::*;
#(
    parameter int TIME_BITS = 16,
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [TIME_BITS-1:0] dur,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  logic [TIME_BITS-1:0] arg,
    input  mode_t                up_mode,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output logic [FRAC_BITS:0]   ratio,
    output mode_t                dn_mode
);

    localparam int STAGES = FRAC_BITS + 1;

    logic                 v_reg    [STAGES];
    logic [TIME_BITS-1:0] rem_reg  [STAGES];
    logic [FRAC_BITS:0]   q_reg    [STAGES];
    mode_t                mode_reg [STAGES];
    logic [STAGES:0]      rdy;

    assign rdy[STAGES] = dn_ready;
    assign up_ready    = rdy[0];

    for (genvar j = 0; j < STAGES; j++)
    begin : g_stage
        logic                 v_up;
        logic [TIME_BITS:0]   trial;
        logic [FRAC_BITS:0]   q_in;
        mode_t                mode_in;
        logic                 bit_q;
        logic [TIME_BITS:0]   sub;
        logic [TIME_BITS-1:0] rem_next;
        logic [FRAC_BITS:0]   q_next;

        if (j == 0)
        begin : g_first
            assign v_up    = up_valid;
            assign trial   = {1'b0, arg};
            assign q_in    = '0;
            assign mode_in = up_mode;
        end
        else
        begin : g_rest
            assign v_up    = v_reg[j-1];
            assign trial   = {rem_reg[j-1], 1'b0};
            assign q_in    = q_reg[j-1];
            assign mode_in = mode_reg[j-1];
        end

        assign rdy[j] = !v_reg[j] || rdy[j+1];

        // Trial subtract and set one quotient bit
        always_comb
        begin
            bit_q    = (trial >= {1'b0, dur});
            sub      = trial - {1'b0, dur};
            rem_next = bit_q ? sub[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
            q_next   = q_in;
            q_next[FRAC_BITS-j] = bit_q;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else if (rdy[j])
                v_reg[j] <= v_up;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[j] && v_up)
            begin
                rem_reg[j]  <= rem_next;
                q_reg[j]    <= q_next;
                mode_reg[j] <= mode_in;
            end
        end
    end

    assign dn_valid = v_reg[STAGES-1];
    assign ratio    = q_reg[STAGES-1];
    assign dn_mode  = mode_reg[STAGES-1];

endmodule

### hw/rtl/bec_curve.sv
// Bounce ease-out evaluation in three stages: segment, square, level and fold.
// Depends on bec_pkg and bounce_easing_curve_macros.svh.
`timescale 1ns / 1ps
`include "bounce_easing_curve_macros.svh"

module bec_curve import bec_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  logic [FRAC_BITS:0] ratio,
    input  mode_t              up_mode,
    output logic               dn_valid,
    input  logic               dn_ready,
    output logic [FRAC_BITS:0] frac,
    output mode_t              dn_mode
);

    localparam int XW = FRAC_BITS + 5;
    localparam int UW = FRAC_BITS + 6;
    localparam int AW = FRAC_BITS + 3;
    localparam int SW = 2 * AW;
    localparam logic [XW-1:0] BRK1 = XW'(4) << FRAC_BITS;
    localparam logic [XW-1:0] BRK2 = XW'(8) << FRAC_BITS;
    localparam logic [XW-1:0] BRK3 = XW'(10) << FRAC_BITS;
    localparam logic [UW-1:0] OFS1 = UW'(12) << FRAC_BITS;
    localparam logic [UW-1:0] OFS2 = UW'(18) << FRAC_BITS;
    localparam logic [UW-1:0] OFS3 = UW'(21) << FRAC_BITS;
    localparam logic [FRAC_BITS-1:0] LVL1 = FRAC_BITS'(3) << (FRAC_BITS - 2);
    localparam logic [FRAC_BITS-1:0] LVL2 = FRAC_BITS'(15) << (FRAC_BITS - 4);
    localparam logic [FRAC_BITS-1:0] LVL3 = FRAC_BITS'(63) << (FRAC_BITS - 6);
    localparam logic [FRAC_BITS:0]   ONE  = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [AW:0]          UMAX = (AW + 1)'(8) << FRAC_BITS;

    logic                 v1_reg, v2_reg, v3_reg;
    logic                 ld1, ld2, ld3;
    logic [AW-1:0]        u_reg, u_next;
    logic [FRAC_BITS-1:0] k1_reg, k_next, k2_reg;
    mode_t                m1_reg, m2_reg, m3_reg;
    logic [SW-1:0]        sq_reg;
    logic [FRAC_BITS:0]   f_reg, f_next;
    logic [XW-1:0]        x11;
    logic [UW-1:0]        u22, ofs, ud;
    logic [FRAC_BITS:0]   fo;
    logic [FRAC_BITS:0]   inv;
    logic [FRAC_BITS+1:0] hi;

    assign ld3      = !v3_reg || dn_ready;
    assign ld2      = !v2_reg || ld3;
    assign ld1      = !v1_reg || ld2;
    assign up_ready = ld1;

    // Pick the segment and take the distance from its centre
    always_comb
    begin
        x11 = XW'(ratio) * XW'(11);
        u22 = {x11, 1'b0};
        priority if (x11 < BRK1)
        begin
            ofs = '0;   k_next = '0;
        end
        else if (x11 < BRK2)
        begin
            ofs = OFS1; k_next = LVL1;
        end
        else if (x11 < BRK3)
        begin
            ofs = OFS2; k_next = LVL2;
        end
        else
        begin
            ofs = OFS3; k_next = LVL3;
        end
        ud     = (u22 >= ofs) ? (u22 - ofs) : (ofs - u22);
        u_next = ud[AW-1:0];
    end

    // Scale the square, add the level and fold for the variant
    always_comb
    begin
        fo  = (FRAC_BITS + 1)'(sq_reg[SW-1:FRAC_BITS+6]) + (FRAC_BITS + 1)'(k2_reg);
        inv = ONE - fo;
        hi  = {1'b0, fo} + {1'b0, ONE};
        unique case (m2_reg)
            MODE_IN:  f_next = inv;
            MODE_LO:  f_next = {1'b0, inv[FRAC_BITS:1]};
            MODE_HI:  f_next = hi[FRAC_BITS+1:1];
            default:  f_next = fo;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= up_valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && up_valid)
        begin
            u_reg  <= u_next;
            k1_reg <= k_next;
            m1_reg <= up_mode;
        end
        if (ld2 && v1_reg)
        begin
            sq_reg <= u_reg * u_reg;
            k2_reg <= k1_reg;
            m2_reg <= m1_reg;
        end
        if (ld3 && v2_reg)
        begin
            f_reg  <= f_next;
            m3_reg <= m2_reg;
        end
    end

    assign dn_valid = v3_reg;
    assign frac     = f_reg;
    assign dn_mode  = m3_reg;

    `BEC_ASSERT_IMPL(a_ratio_le_one, up_valid, ratio <= ONE, "ratio above one")
    `BEC_ASSERT_IMPL(a_dist_bound, v1_reg, {1'b0, u_reg} < UMAX, "segment distance too large")
    `BEC_ASSERT_IMPL(a_frac_le_one, v3_reg, f_reg <= ONE, "curve value above one")
    `BEC_ASSERT_NEXT(a_sq_advance, v1_reg && ld2, v2_reg, "square stage lost a transfer")

endmodule

### hw/rtl/bec_scale.sv
// Output stages: change times curve value, then add start and saturate.
// Depends on bec_pkg.
`timescale 1ns / 1ps

module bec_scale import bec_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [VAL_BITS-1:0] start_value,
    input  logic signed [VAL_BITS-1:0] change,
    input  logic                       up_valid,
    output logic                       up_ready,
    input  logic [FRAC_BITS:0]         frac,
    output logic                       dn_valid,
    input  logic                       dn_stall,
    output logic signed [VAL_BITS-1:0] eased_value
);

    localparam int PW = VAL_BITS + FRAC_BITS + 2;
    localparam int QW = PW - FRAC_BITS;
    localparam int SUMW = QW + 1;
    localparam logic signed [SUMW-1:0] VMAX = SUMW'({1'b0, {(VAL_BITS-1){1'b1}}});
    localparam logic signed [SUMW-1:0] VMIN = -VMAX - SUMW'(1);

    logic                       v1_reg, v2_reg, ld1, ld2;
    logic signed [PW-1:0]       p_reg;
    logic signed [VAL_BITS-1:0] out_reg, out_next;
    logic signed [QW-1:0]       q;
    logic signed [SUMW-1:0]     sum;

    assign ld2      = !v2_reg || !dn_stall;
    assign ld1      = !v1_reg || ld2;
    assign up_ready = ld1;

    // Floor the product and saturate the sum
    always_comb
    begin
        q   = p_reg[PW-1:FRAC_BITS];
        sum = SUMW'(start_value) + SUMW'(q);
        if (sum > VMAX)
            out_next = VMAX[VAL_BITS-1:0];
        else if (sum < VMIN)
            out_next = VMIN[VAL_BITS-1:0];
        else
            out_next = sum[VAL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= up_valid;
            if (ld2) v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1 && up_valid)
            p_reg <= PW'(change) * $signed({1'b0, frac});
        if (ld2 && v1_reg)
            out_reg <= out_next;
    end

    assign dn_valid    = v2_reg;
    assign eased_value = out_reg;

endmodule

### hw/rtl/bounce_easing_curve.sv
// Channel  | Handshake          | Payload
// in       | in_valid/in_stall  | elapsed
// out      | out_valid/out_stall| eased_value
// cfg      | cfg_write          | cfg_index, cfg_data
// One item enters per cycle unless a stall holds it off; the path runs through
// the prep stage, the one-bit-a-stage ratio divider, then curve and scaling stages.
// Reset clears all valid bits and loads the register defaults; no clearing pass.
// Stalls ripple back stage by stage, so bubbles fill before input is held off.
// Top level; depends on bec_pkg, bec_prep, bec_div, bec_curve, bec_scale.
`timescale 1ns / 1ps

module bounce_easing_curve import bec_pkg::*;
#(
    parameter int TIME_BITS = 16,
    parameter int FRAC_BITS = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [1:0]                 cfg_index,
    input  logic [VAL_BITS-1:0]        cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [TIME_BITS-1:0]       elapsed,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [VAL_BITS-1:0] eased_value
);

    logic [1:0]                 variant_reg;
    logic [DUR_BITS-1:0]        duration_reg;
    logic signed [VAL_BITS-1:0] start_reg, change_reg;
    logic [TIME_BITS-1:0]       dur;
    logic                       prep_ready, a_valid, div_ready, b_valid;
    logic                       curve_ready, c_valid, scale_ready;
    logic [TIME_BITS-1:0]       a_arg;
    mode_t                      a_mode, b_mode, c_mode;
    logic [FRAC_BITS:0]         b_ratio, c_frac;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg  <= VAR_OUT;
            duration_reg <= DUR_BITS'(256);
            start_reg    <= '0;
            change_reg   <= VAL_BITS'(65536);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_VARIANT:  variant_reg  <= cfg_data[1:0];
                REG_DURATION: duration_reg <= cfg_data[DUR_BITS-1:0];
                REG_START:    start_reg    <= cfg_data;
                REG_CHANGE:   change_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Fit the duration to the time width and treat zero as one tick
    always_comb
    begin
        dur = '0;
        for (int i = 0; i < TIME_BITS; i++)
            if (i < DUR_BITS)
                dur[i] = duration_reg[i];
        if (dur == '0)
            dur = TIME_BITS'(1);
    end

    assign in_stall = !prep_ready;

    bec_prep #(.TIME_BITS(TIME_BITS)) u_prep (
        .clk(clk), .rst_n(rst_n), .variant(variant_reg), .dur(dur),
        .up_valid(in_valid), .up_ready(prep_ready), .elapsed(elapsed),
        .dn_valid(a_valid), .dn_ready(div_ready), .arg(a_arg), .mode(a_mode)
    );

    bec_div #(.TIME_BITS(TIME_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .dur(dur),
        .up_valid(a_valid), .up_ready(div_ready), .arg(a_arg), .up_mode(a_mode),
        .dn_valid(b_valid), .dn_ready(curve_ready), .ratio(b_ratio), .dn_mode(b_mode)
    );

    bec_curve #(.FRAC_BITS(FRAC_BITS)) u_curve (
        .clk(clk), .rst_n(rst_n),
        .up_valid(b_valid), .up_ready(curve_ready), .ratio(b_ratio), .up_mode(b_mode),
        .dn_valid(c_valid), .dn_ready(scale_ready), .frac(c_frac), .dn_mode(c_mode)
    );

    bec_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
        .clk(clk), .rst_n(rst_n), .start_value(start_reg), .change(change_reg),
        .up_valid(c_valid), .up_ready(scale_ready), .frac(c_frac),
        .dn_valid(out_valid), .dn_stall(out_stall), .eased_value(eased_value)
    );

endmodule
